/* sv/phpf_pkg.sv */
`default_nettype none
package phpf_pkg;

  // edge table depth
  localparam int MAX_EDGES = 8;
  localparam int EIDX_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);

  // shared divider: unsigned numerator / denominator, one quotient bit a cycle
  localparam int DIV_NW    = 52;
  localparam int DIV_DW    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

  // square root: two radicand bits a cycle
  localparam int ROOT_W    = 31;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int SQ_CNT_W  = $clog2(ROOT_W + 1);

  // contact tolerance at scale 2^-26
  localparam int EPS_Q26   = 6711;

  // input item kinds carried on tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef struct packed {
    logic signed [15:0] off;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } edge_entry_t;

  typedef enum logic [2:0] {
    REG_FACE_NX    = 3'd0,
    REG_FACE_NY    = 3'd1,
    REG_FACE_NZ    = 3'd2,
    REG_PLANE_OFF  = 3'd3,
    REG_FRICTION   = 3'd4,
    REG_EDGE_COUNT = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

/* sv/polygon_haptic_proxy_friction_unit.sv */
`default_nettype none
// items: a load gives no item; a query gives one item, soonest when the face plane test
// misses and latest on a clamped hit
// throughput: one item at a time; set by the one-bit-a-cycle divider (up to six uses)
// and the two-bits-a-cycle square root behind the shared multiplier
// reset: synchronous active-low rst_n restores the register defaults and idles the
// sequencer; the edge table is not cleared and holds garbage until loaded
module polygon_haptic_proxy_friction_unit import phpf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // edge_index, edge_nx, edge_ny, edge_nz, edge_offset, proxy_x, proxy_y, proxy_z,
  // device_x, device_y, device_z, zero pad
  input  wire logic [167:0] in_tdata,
  // cmd
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_x, new_y, new_z, contact_nx, contact_ny, contact_nz
  output logic [95:0]       out_tdata,
  // hit
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DOT_W  = 34;
  localparam int ACC_W  = 62;
  localparam int C_W    = 32;
  localparam int F_W    = 20;
  localparam int G_W    = 33;
  localparam int R_W    = 24;
  localparam int NV_W   = 33;

  localparam logic signed [DOT_W-1:0] EPS    = DOT_W'(EPS_Q26);
  localparam logic signed [NV_W-1:0]  SAT_HI = NV_W'(32767);
  localparam logic signed [NV_W-1:0]  SAT_LO = -NV_W'(32768);
  localparam logic [PROD_W-1:0]       HALF28 = PROD_W'(1) << 27;

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_PD_MUL = 25'h0000002,
    S_PD_USE = 25'h0000004,
    S_DD_MUL = 25'h0000008,
    S_DD_USE = 25'h0000010,
    S_CHK    = 25'h0000020,
    S_CX_MUL = 25'h0000040,
    S_CX_ST  = 25'h0000080,
    S_CX_WT  = 25'h0000100,
    S_EG_MUL = 25'h0000200,
    S_EG_USE = 25'h0000400,
    S_F_MUL  = 25'h0000800,
    S_F_USE  = 25'h0001000,
    S_S_MUL  = 25'h0002000,
    S_S_USE  = 25'h0004000,
    S_R_MUL  = 25'h0008000,
    S_R_USE  = 25'h0010000,
    S_RR_MUL = 25'h0020000,
    S_RR_USE = 25'h0040000,
    S_SQ_ST  = 25'h0080000,
    S_SQ_WT  = 25'h0100000,
    S_NV_MUL = 25'h0200000,
    S_NV_ST  = 25'h0400000,
    S_NV_WT  = 25'h0800000,
    S_DONE   = 25'h1000000
  } state_t;

  function automatic logic [15:0] sat16(input logic signed [NV_W-1:0] v);
    if (v > SAT_HI) return 16'h7FFF;
    else if (v < SAT_LO) return 16'h8000;
    else return v[15:0];
  endfunction

  // configuration registers
  logic signed [15:0] face_n_r [3];
  logic signed [15:0] plane_off_r;
  logic [15:0]        fric_r;
  logic [3:0]         edge_cnt_r;

  // edge table, plain flops, read at one place
  edge_entry_t edge_tab_r [MAX_EDGES];

  // sequencer and datapath registers
  state_t                    state_r;
  logic [1:0]                idx_r;
  logic [CNT_W-1:0]          k_r;
  logic signed [15:0]        p_r [3];
  logic signed [15:0]        d_r [3];
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DOT_W-1:0]   pd_r;
  logic signed [DOT_W-1:0]   dd_r;
  logic signed [DOT_W-1:0]   a_r;
  logic signed [DOT_W-1:0]   den_r;
  logic signed [C_W-1:0]     c_r [3];
  logic signed [F_W-1:0]     f_r [3];
  logic [SQ_W-1:0]           s_r;
  logic [R_W-1:0]            r_r;
  logic signed [NV_W-1:0]    nv_r [3];
  logic                      hit_r;

  // output register
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [15:0]               out_new_r [3];
  logic [15:0]               out_n_r [3];

  // input fields
  logic [2:0]  in_edge_idx;
  edge_entry_t in_edge;
  logic signed [15:0] in_p [3];
  logic signed [15:0] in_d [3];

  assign in_edge_idx = in_tdata[2:0];
  assign in_edge.nx  = in_tdata[18:3];
  assign in_edge.ny  = in_tdata[34:19];
  assign in_edge.nz  = in_tdata[50:35];
  assign in_edge.off = in_tdata[66:51];
  assign in_p[0]     = in_tdata[82:67];
  assign in_p[1]     = in_tdata[98:83];
  assign in_p[2]     = in_tdata[114:99];
  assign in_d[0]     = in_tdata[130:115];
  assign in_d[1]     = in_tdata[146:131];
  assign in_d[2]     = in_tdata[162:147];

  // shared multiplier operands, picked by sequencer state
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic                    mul_en;
  edge_entry_t             e_cur;
  logic signed [15:0]      e_n;
  logic signed [G_W-1:0]   g_cur;

  assign e_cur = edge_tab_r[k_r[EIDX_W-1:0]];
  assign g_cur = G_W'(c_r[idx_r]) - G_W'(f_r[idx_r]);

  always_comb begin
    case (idx_r)
      2'd0:    e_n = e_cur.nx;
      2'd1:    e_n = e_cur.ny;
      default: e_n = e_cur.nz;
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_r)
      S_PD_MUL: begin
        mul_a = MUL_W'(p_r[idx_r]);
        mul_b = MUL_W'(face_n_r[idx_r]);
      end
      S_DD_MUL: begin
        mul_a = MUL_W'(d_r[idx_r]);
        mul_b = MUL_W'(face_n_r[idx_r]);
      end
      S_CX_MUL: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(p_r[idx_r]) - MUL_W'(d_r[idx_r]);
      end
      S_EG_MUL: begin
        mul_a = MUL_W'(c_r[idx_r]);
        mul_b = MUL_W'(e_n);
      end
      S_F_MUL: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(face_n_r[idx_r]);
      end
      S_S_MUL: begin
        mul_a = MUL_W'(g_cur);
        mul_b = MUL_W'(g_cur);
      end
      S_R_MUL: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'($signed({1'b0, fric_r}));
      end
      S_RR_MUL: begin
        mul_a = MUL_W'($signed({1'b0, r_r}));
        mul_b = MUL_W'($signed({1'b0, r_r}));
      end
      S_NV_MUL: begin
        mul_a = MUL_W'($signed({1'b0, r_r}));
        mul_b = MUL_W'(g_cur);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // product magnitude for the sign-magnitude rounding paths
  logic [PROD_W-1:0] prod_mag;
  logic              prod_neg;
  assign prod_neg = prod_r[PROD_W-1];
  assign prod_mag = prod_neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  // round half away from zero over 2^28 for the face projection
  logic [F_W-1:0]        f_mag;
  logic signed [F_W-1:0] f_q;
  assign f_mag = F_W'((prod_mag + HALF28) >> 28);
  assign f_q   = prod_neg ? -$signed(f_mag) : $signed(f_mag);

  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] edge_lim;
  logic signed [DOT_W-1:0] pos_w;
  logic                    plane_hit;
  logic [CNT_W-1:0]        cnt_lim;

  assign acc_sum   = acc_r + ACC_W'(prod_r);
  assign edge_lim  = {{(ACC_W-30){e_cur.off[15]}}, e_cur.off, 14'b0};
  assign pos_w     = {{(DOT_W-30){plane_off_r[15]}}, plane_off_r, 14'b0};
  assign plane_hit = (pd_r >= pos_w - EPS) && (pos_w >= dd_r);
  assign cnt_lim   = (int'(edge_cnt_r) > MAX_EDGES) ? CNT_W'(MAX_EDGES) : CNT_W'(edge_cnt_r);

  // divider and square root
  logic                  div_start;
  logic [DIV_NW-1:0]     div_num;
  logic [DIV_DW-1:0]     div_den;
  logic [DIV_NW-1:0]     div_quo;
  iter_stat_t            div_stat;
  logic                  sq_start;
  logic [ROOT_W-1:0]     sq_root;
  iter_stat_t            sq_stat;
  logic [C_W-1:0]        quo_c;
  logic signed [C_W-1:0] q_s;

  assign div_start = (state_r == S_CX_ST) || (state_r == S_NV_ST);
  assign div_den   = (state_r == S_NV_ST) ? DIV_DW'(sq_root) : den_r[DIV_DW-1:0];
  // rounded quotient: (|num| + den/2) / den, sign put back after
  assign div_num   = DIV_NW'(prod_mag) + DIV_NW'(div_den >> 1);
  assign quo_c     = C_W'(div_quo);
  assign q_s       = prod_neg ? -$signed(quo_c) : $signed(quo_c);
  assign sq_start  = (state_r == S_SQ_ST);

  phpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  phpf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (s_r),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  // handshakes
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_n_r[0] <= 16'sd0;
      face_n_r[1] <= 16'sd0;
      face_n_r[2] <= 16'sd16384;
      plane_off_r <= 16'sd0;
      fric_r      <= 16'd0;
      edge_cnt_r  <= 4'd0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FACE_NX:    face_n_r[0] <= cfg_data;
        REG_FACE_NY:    face_n_r[1] <= cfg_data;
        REG_FACE_NZ:    face_n_r[2] <= cfg_data;
        REG_PLANE_OFF:  plane_off_r <= cfg_data;
        REG_FRICTION:   fric_r      <= cfg_data;
        REG_EDGE_COUNT: edge_cnt_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // edge table loads, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && (in_tuser[0] == CMD_LOAD) &&
        (int'(in_edge_idx) < MAX_EDGES)) begin
      edge_tab_r[EIDX_W'(in_edge_idx)] <= in_edge;
    end
  end

  // shared product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register fills from the done state, empties on an accepted item
      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && (in_tuser[0] == CMD_QUERY)) begin
            for (int i = 0; i < 3; i++) begin
              p_r[i] <= in_p[i];
              d_r[i] <= in_d[i];
            end
            idx_r   <= 2'd0;
            acc_r   <= '0;
            state_r <= S_PD_MUL;
          end
        end

        // proxy and device dotted with the face normal
        S_PD_MUL: state_r <= S_PD_USE;
        S_PD_USE: begin
          if (idx_r == 2'd2) begin
            pd_r    <= DOT_W'(acc_sum);
            acc_r   <= '0;
            idx_r   <= 2'd0;
            state_r <= S_DD_MUL;
          end else begin
            acc_r   <= acc_sum;
            idx_r   <= idx_r + 2'd1;
            state_r <= S_PD_MUL;
          end
        end
        S_DD_MUL: state_r <= S_DD_USE;
        S_DD_USE: begin
          if (idx_r == 2'd2) begin
            dd_r    <= DOT_W'(acc_sum);
            acc_r   <= '0;
            idx_r   <= 2'd0;
            state_r <= S_CHK;
          end else begin
            acc_r   <= acc_sum;
            idx_r   <= idx_r + 2'd1;
            state_r <= S_DD_MUL;
          end
        end

        // plane contact test
        S_CHK: begin
          den_r <= pd_r - dd_r;
          a_r   <= pos_w - dd_r;
          if (plane_hit) begin
            state_r <= S_CX_MUL;
          end else begin
            hit_r <= 1'b0;
            for (int i = 0; i < 3; i++) nv_r[i] <= NV_W'(p_r[i]);
            state_r <= S_DONE;
          end
        end

        // segment crossing, device point when the denominator is not positive
        S_CX_MUL: begin
          if (den_r <= 0) begin
            c_r[idx_r] <= C_W'(d_r[idx_r]);
            if (idx_r == 2'd2) begin
              idx_r   <= 2'd0;
              acc_r   <= '0;
              k_r     <= '0;
              state_r <= (cnt_lim == '0) ? S_F_MUL : S_EG_MUL;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end else begin
            state_r <= S_CX_ST;
          end
        end
        S_CX_ST: state_r <= S_CX_WT;
        S_CX_WT: begin
          if (div_stat.done) begin
            c_r[idx_r] <= C_W'(d_r[idx_r]) + q_s;
            if (idx_r == 2'd2) begin
              idx_r   <= 2'd0;
              acc_r   <= '0;
              k_r     <= '0;
              state_r <= (cnt_lim == '0) ? S_F_MUL : S_EG_MUL;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_CX_MUL;
            end
          end
        end

        // edge walk, first failing edge ends the query as a miss
        S_EG_MUL: state_r <= S_EG_USE;
        S_EG_USE: begin
          if (idx_r == 2'd2) begin
            acc_r <= '0;
            idx_r <= 2'd0;
            if (acc_sum < edge_lim) begin
              hit_r <= 1'b0;
              for (int i = 0; i < 3; i++) nv_r[i] <= NV_W'(p_r[i]);
              state_r <= S_DONE;
            end else if (k_r + 1'b1 == cnt_lim) begin
              state_r <= S_F_MUL;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_EG_MUL;
            end
          end else begin
            acc_r   <= acc_sum;
            idx_r   <= idx_r + 2'd1;
            state_r <= S_EG_MUL;
          end
        end

        // device projection onto the face
        S_F_MUL: state_r <= S_F_USE;
        S_F_USE: begin
          f_r[idx_r] <= F_W'(d_r[idx_r]) + f_q;
          if (idx_r == 2'd2) begin
            idx_r   <= 2'd0;
            acc_r   <= '0;
            state_r <= S_S_MUL;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_F_MUL;
          end
        end

        // squared distance from projection to crossing
        S_S_MUL: state_r <= S_S_USE;
        S_S_USE: begin
          if (idx_r == 2'd2) begin
            s_r     <= SQ_W'(acc_sum);
            idx_r   <= 2'd0;
            state_r <= S_R_MUL;
          end else begin
            acc_r   <= acc_sum;
            idx_r   <= idx_r + 2'd1;
            state_r <= S_S_MUL;
          end
        end

        // friction radius and its square
        S_R_MUL: state_r <= S_R_USE;
        S_R_USE: begin
          r_r     <= R_W'(prod_r[PROD_W-1:26]);
          state_r <= S_RR_MUL;
        end
        S_RR_MUL: state_r <= S_RR_USE;
        S_RR_USE: begin
          if ({{(PROD_W-SQ_W){1'b0}}, s_r} > $unsigned(prod_r)) begin
            state_r <= S_SQ_ST;
          end else begin
            hit_r <= 1'b1;
            for (int i = 0; i < 3; i++) nv_r[i] <= NV_W'(c_r[i]);
            state_r <= S_DONE;
          end
        end

        // outside the cone: pull back onto the circle
        S_SQ_ST: state_r <= S_SQ_WT;
        S_SQ_WT: begin
          if (sq_stat.done) begin
            idx_r   <= 2'd0;
            state_r <= S_NV_MUL;
          end
        end
        S_NV_MUL: state_r <= S_NV_ST;
        S_NV_ST:  state_r <= S_NV_WT;
        S_NV_WT: begin
          if (div_stat.done) begin
            nv_r[idx_r] <= NV_W'(f_r[idx_r]) + NV_W'(q_s);
            if (idx_r == 2'd2) begin
              hit_r   <= 1'b1;
              idx_r   <= 2'd0;
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_NV_MUL;
            end
          end
        end

        // hand the item to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_hit_r <= hit_r;
            for (int i = 0; i < 3; i++) begin
              out_new_r[i] <= sat16(nv_r[i]);
              out_n_r[i]   <= hit_r ? face_n_r[i] : 16'd0;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {out_n_r[2], out_n_r[1], out_n_r[0],
                       out_new_r[2], out_new_r[1], out_new_r[0]};

endmodule
`default_nettype wire

/* sv/phpf_div.sv */
`default_nettype none
module phpf_div import phpf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output iter_stat_t             stat,
  output logic [DIV_NW-1:0]      quo
);

  logic [DIV_DW-1:0]    rem_r;
  logic [DIV_DW-1:0]    den_r;
  logic [DIV_NW-1:0]    qn_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DW:0]      trial;
  logic [DIV_DW:0]      diff;
  logic                 ge;

  // restoring step
  assign trial = {rem_r, qn_r[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      qn_r  <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      qn_r  <= {qn_r[DIV_NW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = qn_r;

endmodule
`default_nettype wire

/* sv/phpf_sqrt.sv */
`default_nettype none
module phpf_sqrt import phpf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] rad,
  output iter_stat_t           stat,
  output logic [ROOT_W-1:0]    root
);

  logic [SQ_W-1:0]     rad_r;
  logic [ROOT_W:0]     rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+2:0]   t;
  logic [ROOT_W+2:0]   trial;
  logic                ge;

  assign t     = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SQ_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= ge ? (ROOT_W+1)'(t - trial) : t[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule
`default_nettype wire
